### rtl/core/cursor_sequence_engine_top_assert.svh
// Assertion macros for the cursor sequence engine checker.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef CURSOR_SEQUENCE_ENGINE_TOP_ASSERT_SVH
`define CURSOR_SEQUENCE_ENGINE_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next one.
`define CSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/cse_pkg.sv
// Shared types and constants for the cursor sequence engine.
// Used by every module of the block and by its checker.
package cse_pkg;

  localparam int CAP_DEFAULT = 32;
  localparam int CAP_MAX     = 256;
  localparam int AT_W        = $clog2(CAP_MAX + 1);

  localparam int CMD_W   = 4;
  localparam int WORD_W  = 64;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 6;
  localparam int CURS_W  = 5;

  localparam logic [CMD_W-1:0] CMD_START        = 4'd0;
  localparam logic [CMD_W-1:0] CMD_END          = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LAST         = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ADVANCE      = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RETREAT      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_INSERT       = 4'd5;
  localparam logic [CMD_W-1:0] CMD_ATTACH       = 4'd6;
  localparam logic [CMD_W-1:0] CMD_REMOVE_CUR   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 4'd8;
  localparam logic [CMD_W-1:0] CMD_INSERT_FRONT = 4'd9;
  localparam logic [CMD_W-1:0] CMD_APPEND       = 4'd10;
  localparam logic [CMD_W-1:0] CMD_READ         = 4'd11;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] value;
    logic [POS_W-1:0]  position;
  } in_beat_t;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] count;
    logic [CURS_W-1:0]  cursor;
    logic               has_current;
    logic [WORD_W-1:0]  current_value;
    logic [WORD_W-1:0]  read_value;
  } out_beat_t;

  // What every cell of the row does on a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_OPEN,
    CELL_CLOSE
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [AT_W-1:0]   at;
    logic [WORD_W-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/core/cse_cell.sv
// One storage cell of the list row: holds one entry word.
// Depends on cse_pkg for the broadcast cell control struct.
module cse_cell import cse_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [WORD_W-1:0] left_q,
  input  logic [WORD_W-1:0] right_q,
  output logic [WORD_W-1:0] word_r
);

  localparam logic [AT_W-1:0] MY_IDX = AT_W'(IDX);

  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    unique case (ctrl.op)
      CELL_OPEN: begin
        // gap opens at ctrl.at: take the new word there, shift up above it
        if (MY_IDX == ctrl.at) begin
          word_nxt = ctrl.value;
        end else if (MY_IDX > ctrl.at) begin
          word_nxt = left_q;
        end
      end
      CELL_CLOSE: begin
        if (MY_IDX >= ctrl.at) begin
          word_nxt = right_q;
        end
      end
      default: begin
        word_nxt = word_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

### rtl/core/cse_ctrl.sv
// Cursor and count control: decodes a command, updates cursor and count,
// and drives the broadcast control for the cell row. Depends on cse_pkg.
module cse_ctrl import cse_pkg::*; #(
  parameter int CAP   = CAP_DEFAULT,
  parameter int CNT_W = $clog2(CAP + 1),
  parameter int CUR_W = $clog2(CAP)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  in_beat_t         cmd_beat,
  output cell_ctrl_t       cell_ctrl,
  output logic             acc,
  output logic             is_read,
  output logic [CNT_W-1:0] count_r,
  output logic [CUR_W-1:0] cursor_r
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAP);
  localparam logic [CUR_W-1:0] TOP_POS  = CUR_W'(CAP - 1);

  logic [CNT_W-1:0] count_nxt;
  logic [CUR_W-1:0] cursor_nxt;
  logic             cur;
  logic             full;
  cell_op_t         op;
  logic [CNT_W-1:0] at;

  assign cur  = CNT_W'(cursor_r) < count_r;
  assign full = count_r == FULL_CNT;

  always_comb begin
    acc        = 1'b1;
    is_read    = 1'b0;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    op         = CELL_HOLD;
    at         = '0;
    unique case (cmd_beat.command)
      CMD_START: begin
        cursor_nxt = '0;
      end
      CMD_END: begin
        cursor_nxt = (count_r != '0) ? CUR_W'(count_r - 1'b1) : '0;
      end
      CMD_LAST: begin
        cursor_nxt = TOP_POS;
      end
      CMD_ADVANCE: begin
        if (!cur || cursor_r == TOP_POS) begin
          acc = 1'b0;
        end else begin
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      CMD_RETREAT: begin
        if (cursor_r == '0) begin
          acc = 1'b0;
        end else begin
          cursor_nxt = cursor_r - 1'b1;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          acc = 1'b0;
        end else begin
          at         = cur ? CNT_W'(cursor_r) : '0;
          op         = CELL_OPEN;
          cursor_nxt = cur ? cursor_r : '0;
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_ATTACH: begin
        if (full) begin
          acc = 1'b0;
        end else begin
          // with no current item, attach lands at the tail
          at         = cur ? CNT_W'(cursor_r) + 1'b1 : count_r;
          op         = CELL_OPEN;
          cursor_nxt = cur ? cursor_r + 1'b1 : CUR_W'(count_r);
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_REMOVE_CUR: begin
        if (!cur) begin
          acc = 1'b0;
        end else begin
          at        = CNT_W'(cursor_r);
          op        = CELL_CLOSE;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_REMOVE_FRONT: begin
        if (!cur) begin
          acc = 1'b0;
        end else begin
          op         = CELL_CLOSE;
          cursor_nxt = '0;
          count_nxt  = count_r - 1'b1;
        end
      end
      CMD_INSERT_FRONT: begin
        if (full) begin
          acc = 1'b0;
        end else begin
          op         = CELL_OPEN;
          cursor_nxt = '0;
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_APPEND: begin
        if (full) begin
          acc = 1'b0;
        end else begin
          at         = count_r;
          op         = CELL_OPEN;
          cursor_nxt = CUR_W'(count_r);
          count_nxt  = count_r + 1'b1;
        end
      end
      CMD_READ: begin
        is_read = 1'b1;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  always_comb begin
    cell_ctrl.op    = accept ? op : CELL_HOLD;
    cell_ctrl.at    = AT_W'(at);
    cell_ctrl.value = cmd_beat.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
    end else if (accept) begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

endmodule

### rtl/core/cursor_sequence_engine_top.sv
// Top level of the cursor sequence engine: control, cell row, result stage.
// Depends on cse_pkg, cse_ctrl and cse_cell.
//
// A list of up to CAPACITY_WORDS 64-bit entries with a cursor, driven by one
// command per beat. A command is taken at a rising edge with start high and
// busy low; busy is raised only by reset and falls once reset is released, so
// a new command may follow in every cycle. Each command gives exactly one
// result beat: out_valid is high for exactly one cycle, and the result is
// taken at the edge that ends that cycle. The receiver cannot stall the
// block, so results must be captured when they appear. The result of a
// command is built in turn: first the cell row, cursor and count move,
// then the output register picks the current entry and the read entry out
// of the row. Every insert or removal is one parallel shift of the whole
// row, so no command's work depends on the list length. Entries never
// written read as undefined, but only entries below the count are
// ever shown.
module cursor_sequence_engine_top import cse_pkg::*; #(
  parameter int CAPACITY_WORDS = CAP_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  output out_beat_t out_beat
);

  localparam int CNT_W = $clog2(CAPACITY_WORDS + 1);
  localparam int CUR_W = $clog2(CAPACITY_WORDS);

  logic              accept;
  logic              busy_r;
  cell_ctrl_t        cell_ctrl;
  logic              acc;
  logic              is_read;
  logic [CNT_W-1:0]  count_r;
  logic [CUR_W-1:0]  cursor_r;
  logic [WORD_W-1:0] cell_q [CAPACITY_WORDS];

  // pending-result stage: what the output register needs besides the row
  logic              pend_r;
  logic              acc_r;
  logic              rd_r;
  logic [POS_W-1:0]  pos_r;

  logic              out_valid_r;
  out_beat_t         out_beat_r;
  out_beat_t         out_beat_nxt;
  logic              has_cur;
  logic              pos_ok;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Set busy during reset; clear it once reset is released.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  cse_ctrl #(
    .CAP   (CAPACITY_WORDS),
    .CNT_W (CNT_W),
    .CUR_W (CUR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd_beat  (in_beat),
    .cell_ctrl (cell_ctrl),
    .acc       (acc),
    .is_read   (is_read),
    .count_r   (count_r),
    .cursor_r  (cursor_r)
  );

  // Row of cells; each takes from its left neighbor to open a gap and from
  // its right neighbor to close one. The ends see zero past the row.
  for (genvar i = 0; i < CAPACITY_WORDS; i++) begin : g_cell
    logic [WORD_W-1:0] left_q;
    logic [WORD_W-1:0] right_q;

    if (i == 0) begin : g_left_end
      assign left_q = '0;
    end else begin : g_left_mid
      assign left_q = cell_q[i-1];
    end

    if (i == CAPACITY_WORDS - 1) begin : g_right_end
      assign right_q = '0;
    end else begin : g_right_mid
      assign right_q = cell_q[i+1];
    end

    cse_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .left_q  (left_q),
      .right_q (right_q),
      .word_r  (cell_q[i])
    );
  end

  // Latch what the result beat needs; the row, cursor and count settle on
  // the same edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_r <= acc;
      rd_r  <= is_read;
      pos_r <= in_beat.position;
    end
  end

  // Pick the current and read entries from the settled row.
  assign has_cur = CNT_W'(cursor_r) < count_r;
  assign pos_ok  = 32'(pos_r) < 32'(count_r);

  always_comb begin
    out_beat_nxt.accepted      = acc_r;
    out_beat_nxt.count         = COUNT_W'(count_r);
    out_beat_nxt.cursor        = CURS_W'(cursor_r);
    out_beat_nxt.has_current   = has_cur;
    out_beat_nxt.current_value = has_cur ? cell_q[cursor_r] : '0;
    out_beat_nxt.read_value    = (rd_r && pos_ok) ? cell_q[CUR_W'(pos_r)] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      out_beat_r <= out_beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

### rtl/core/cse_checker.sv
// Port-level checker for the cursor sequence engine, bound to the top level.
// Depends on cse_pkg and the assertion macro header.
`include "cursor_sequence_engine_top_assert.svh"

module cse_port_checker import cse_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_beat_t  in_beat,
  input logic      out_valid,
  input out_beat_t out_beat
);

  logic [1:0]       seen_r;
  logic [CMD_W-1:0] cmd_r;
  logic             show_cur;
  logic             show_none;
  logic             cur_ok;
  logic             zero_ok;
  logic             start_seen;
  logic             home_ok;

  // Track accepted beats through seen_r; the second stage lines up
  // with the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else begin
      seen_r <= {seen_r[0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= in_beat.command;
  end

  assign show_cur   = out_valid && out_beat.has_current;
  assign show_none  = out_valid && !out_beat.has_current;
  assign cur_ok     = COUNT_W'(out_beat.cursor) < out_beat.count;
  assign zero_ok    = out_beat.current_value == '0;
  assign start_seen = seen_r[0] && (cmd_r == CMD_START);
  assign home_ok    = out_valid && (out_beat.cursor == '0) && out_beat.accepted;

  `CSE_ASSERT_SAME(a_result_follows, seen_r[1], out_valid, "accepted beat gave no result")
  `CSE_ASSERT_SAME(a_no_spurious, !seen_r[1], !out_valid, "result without accepted beat")
  `CSE_ASSERT_SAME(a_cur_in_range, show_cur, cur_ok, "current item past count")
  `CSE_ASSERT_SAME(a_no_cur_zero, show_none, zero_ok, "current value without current item")
  `CSE_ASSERT_NEXT(a_start_home, start_seen, home_ok, "start did not home the cursor")

endmodule

bind cursor_sequence_engine_top cse_port_checker u_cse_checker (.*);

### tb/sv/cse_checker.sv
`timescale 1ns / 1ps
// Result checker for cursor_sequence_engine_top: shadows the list and cursor,
// predicts one status beat per command and compares. Depends on cse_pkg.
module cse_checker import cse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_beat_t  in_beat,
  input  logic      out_valid,
  input  out_beat_t out_beat,
  output int        mismatch_total,
  output int        results_owed
);

  localparam int CAP = CAP_DEFAULT;

  logic [WORD_W-1:0]  slot_word [CAP];
  logic [COUNT_W-1:0] slot_count;
  logic [CURS_W-1:0]  cursor_slot;
  out_beat_t          owed_status [$];
  int                 bad_total = 0;
  int                 owed_total = 0;

  assign mismatch_total = bad_total;
  assign results_owed   = owed_total;

  // Shift entries [at, n) up by one slot.
  function automatic void open_slot(int at, int n);
    for (int i = n; i > at; i--) slot_word[i] = slot_word[i-1];
  endfunction

  // Shift entries (at, n) down by one slot.
  function automatic void close_slot(int at, int n);
    for (int i = at; i + 1 < n; i++) slot_word[i] = slot_word[i+1];
  endfunction

  // Apply one command to the shadow list and return the status it produces.
  function automatic out_beat_t step_list(in_beat_t cmd);
    int                n;
    int                c;
    bit                has;
    bit                full;
    logic              acc;
    logic [WORD_W-1:0] rd;
    out_beat_t         res;
    n    = slot_count;
    c    = cursor_slot;
    has  = c < n;
    full = n >= CAP;
    acc  = 1'b1;
    rd   = '0;
    case (cmd.command)
      CMD_START: c = 0;
      CMD_END:   c = (n != 0) ? n - 1 : 0;
      CMD_LAST:  c = CAP - 1;
      CMD_ADVANCE: begin
        if (!has || c >= CAP - 1) acc = 1'b0;
        else c++;
      end
      CMD_RETREAT: begin
        if (c == 0) acc = 1'b0;
        else c--;
      end
      CMD_INSERT: begin
        if (full) acc = 1'b0;
        else begin
          if (!has) c = 0;
          open_slot(c, n);
          slot_word[c] = cmd.value;
          n++;
        end
      end
      CMD_ATTACH: begin
        if (full) acc = 1'b0;
        else begin
          if (!has) c = n;
          else begin
            open_slot(c + 1, n);
            c++;
          end
          slot_word[c] = cmd.value;
          n++;
        end
      end
      CMD_REMOVE_CUR: begin
        if (!has) acc = 1'b0;
        else begin
          close_slot(c, n);
          n--;
        end
      end
      CMD_REMOVE_FRONT: begin
        if (!has) acc = 1'b0;
        else begin
          close_slot(0, n);
          n--;
          c = 0;
        end
      end
      CMD_INSERT_FRONT: begin
        if (full) acc = 1'b0;
        else begin
          open_slot(0, n);
          slot_word[0] = cmd.value;
          n++;
          c = 0;
        end
      end
      CMD_APPEND: begin
        if (full) acc = 1'b0;
        else begin
          slot_word[n] = cmd.value;
          n++;
          c = n - 1;
        end
      end
      CMD_READ: begin
        if (int'(cmd.position) < n) rd = slot_word[cmd.position];
      end
      default: acc = 1'b0;
    endcase
    slot_count  = COUNT_W'(n);
    cursor_slot = CURS_W'(c);
    has = c < n;
    res.accepted      = acc;
    res.count         = COUNT_W'(n);
    res.cursor        = CURS_W'(c);
    res.has_current   = has;
    res.current_value = has ? slot_word[c] : '0;
    res.read_value    = rd;
    return res;
  endfunction

  function automatic int field_bad(string name, logic [WORD_W-1:0] want,
                                   logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (!rst_n) begin
      owed_status.delete();
      slot_count  = '0;
      cursor_slot = '0;
    end else begin
      // Retire the oldest prediction first; latency keeps this beat's own
      // prediction out of reach anyway.
      if (out_valid === 1'b1) begin
        if (owed_status.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_beat);
          bad_total++;
        end else begin
          want = owed_status.pop_front();
          bad_total += field_bad("accepted", want.accepted, out_beat.accepted);
          bad_total += field_bad("count", want.count, out_beat.count);
          bad_total += field_bad("cursor", want.cursor, out_beat.cursor);
          bad_total += field_bad("has_current", want.has_current, out_beat.has_current);
          bad_total += field_bad("current_value", want.current_value,
                                 out_beat.current_value);
          bad_total += field_bad("read_value", want.read_value, out_beat.read_value);
        end
      end
      if (start === 1'b1 && busy === 1'b0) owed_status.push_back(step_list(in_beat));
    end
    owed_total = owed_status.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the cursor sequence engine testbench: clock, reset, command stimulus
// and verdict. Depends on cse_pkg, cse_checker and cursor_sequence_engine_top.
module tb_top import cse_pkg::*; ();

  localparam int ITEM_TARGET = 1800;
  // Last stretch of the run goes without sender gaps.
  localparam int QUIET_TAIL  = 200;
  // Longest legal quiet stretch is the longest sender gap plus the result
  // latency, or the reset. Allow far more than that.
  localparam int STALL_LIMIT = 400;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_READ + 4'd1;
  localparam logic [CMD_W-1:0] CMD_TOP_CODE     = 4'd15;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_beat_t  in_beat = '0;
  logic      busy;
  logic      out_valid;
  out_beat_t out_beat;
  int        mismatch_total;
  int        results_owed;
  int        beats_sent   = 0;
  int        quiet_cycles = 0;
  bit        gaps_on      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cursor_sequence_engine_top #(
    .CAPACITY_WORDS(CAP_DEFAULT)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  cse_checker u_list_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_beat        (in_beat),
    .out_valid      (out_valid),
    .out_beat       (out_beat),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  // Watchdog: a long run of cycles with no beat moving on either side
  // means the block hung or dropped a result.
  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < STALL_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Mostly random words, with the all-zero and all-one extremes mixed in.
  function automatic logic [WORD_W-1:0] any_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] grow_command();
    case ($urandom_range(0, 3))
      0:       return CMD_INSERT;
      1:       return CMD_ATTACH;
      2:       return CMD_INSERT_FRONT;
      default: return CMD_APPEND;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] CMD_CODE_PICK();
    return CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_TOP_CODE));
  endfunction

  // Any defined command, with the unused codes now and then.
  function automatic logic [CMD_W-1:0] mixed_command();
    if ($urandom_range(0, 15) == 0)
      return CMD_CODE_PICK();
    return CMD_W'($urandom_range(CMD_START, CMD_READ));
  endfunction

  // Drop start for a gap set by n; scramble the payload so a stray capture shows.
  task automatic pause(input int n);
    start   <= 1'b0;
    in_beat <= '{command: CMD_W'($urandom), value: any_word(),
                 position: POS_W'($urandom)};
    repeat (n) @(posedge clk);
  endtask

  // Present one command beat and hold it until the block takes it.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] val,
                       input logic [POS_W-1:0] pos);
    if (gaps_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 18));
    start   <= 1'b1;
    in_beat <= '{command: cmd, value: val, position: pos};
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd <= CMD_READ) beats_sent++;
  endtask

  // Hold off the sender until every predicted result has come back.
  // Sample the owed count on the falling edge, away from the checker's update.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list corner cases first.
    issue(CMD_READ, '0, 5'd0);           // read beyond count
    issue(CMD_ADVANCE, '0, '0);          // no current item
    issue(CMD_RETREAT, '0, '0);          // already at zero
    issue(CMD_REMOVE_CUR, '0, '0);       // nothing to remove
    issue(CMD_REMOVE_FRONT, '0, '0);
    issue(CMD_END, '0, '0);              // end on empty goes to zero
    // Build a short list through every insertion form.
    issue(CMD_INSERT, '1, '0);           // no current: lands at the front
    issue(CMD_ATTACH, '0, '0);
    issue(CMD_INSERT_FRONT, 64'h8000_0000_0000_0001, '0);
    issue(CMD_APPEND, 64'h5555_5555_5555_5555, '0);
    issue(CMD_READ, '0, 5'd2);
    issue(CMD_READ, '1, 5'd31);          // out of range reads zero
    issue(CMD_LAST, '0, '0);             // cursor parks past the tail
    issue(CMD_ATTACH, 64'hAAAA_AAAA_AAAA_AAAA, '0);  // no current: tail
    issue(CMD_LAST, '0, '0);
    issue(CMD_ADVANCE, '0, '0);          // no current at the top slot
    issue(CMD_INSERT, 64'h0123_4567_89AB_CDEF, '0);  // no current: front
    issue(CMD_ADVANCE, '0, '0);
    issue(CMD_RETREAT, '0, '0);
    issue(CMD_END, '0, '0);
    issue(CMD_REMOVE_CUR, '0, '0);       // removing the tail leaves no current
    issue(CMD_REMOVE_FRONT, '0, '0);     // no current: ignored
    issue(CMD_FIRST_UNUSED, '1, '1);
    issue(CMD_TOP_CODE, '1, '1);
    issue(CMD_START, '0, '0);
    wait_drained();

    // Random: fills past capacity, drains to empty, and mixed runs, with the
    // sender gapping in some stretches and not in others.
    while (beats_sent < ITEM_TARGET) begin
      gaps_on = (beats_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 9))
        0: begin
          // Overfill, then poke the full list at its top slot.
          repeat (34) issue(grow_command(), any_word(), POS_W'($urandom));
          issue(CMD_END, any_word(), POS_W'($urandom));
          issue(CMD_ADVANCE, any_word(), POS_W'($urandom));
          issue(CMD_READ, any_word(), 5'd31);
          issue(grow_command(), any_word(), POS_W'($urandom));
        end
        1: begin
          // Empty the list; restart the cursor now and then so removes land.
          repeat (45) begin
            if ($urandom_range(0, 3) == 0)
              issue(CMD_START, any_word(), POS_W'($urandom));
            else if ($urandom_range(0, 1) == 0)
              issue(CMD_REMOVE_CUR, any_word(), POS_W'($urandom));
            else
              issue(CMD_REMOVE_FRONT, any_word(), POS_W'($urandom));
          end
        end
        default: begin
          repeat ($urandom_range(10, 40))
            issue(mixed_command(), any_word(), POS_W'($urandom));
        end
      endcase
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    // Let the last results land, then wait on for stray beats.
    start <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (mismatch_total == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
